/* sv/psvb_pkg.sv */
// shared types, register indexes and generator helpers for the supersaw voice bank
// no dependencies
package psvb_pkg;

    // per-voice state word kept in the voice memory
    typedef struct packed {
        logic [31:0]        phase;
        logic signed [23:0] offset;
        logic signed [32:0] walk;
        logic [31:0]        gen;
    } voice_t;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 48;

    localparam logic [CFG_AW-1:0] REG_PHASE_INC   = 4'd0;
    localparam logic [CFG_AW-1:0] REG_INVERSE_INC = 4'd1;
    localparam logic [CFG_AW-1:0] REG_VOICE_COUNT = 4'd2;
    localparam logic [CFG_AW-1:0] REG_SPREAD_GAIN = 4'd3;
    localparam logic [CFG_AW-1:0] REG_RANDOM_GAIN = 4'd4;
    localparam logic [CFG_AW-1:0] REG_DRIFT_GAIN  = 4'd5;
    localparam logic [CFG_AW-1:0] REG_DRIFT_STEP  = 4'd6;
    localparam logic [CFG_AW-1:0] REG_OUT_LEVEL   = 4'd7;

    localparam logic OP_RENDER = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam logic [15:0] GAIN_ONE = 16'd32768;

    function automatic logic [31:0] xorshift32(input logic [31:0] g);
        logic [31:0] x;
        x = g;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // (word >> 8) - 2^23 as a signed Q0.24 value
    function automatic logic signed [23:0] draw_of(input logic [31:0] w);
        return $signed({~w[31], w[30:8]});
    endfunction

    function automatic logic [15:0] gain_sat(input logic [15:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

/* sv/psvb_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module psvb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/psvb_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module psvb_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule

/* sv/psvb_mul.sv */
// shared signed 34x34 multiplier with registered product
// no dependencies
module psvb_mul (
    input  logic               aclk,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] p
);
    always_ff @(posedge aclk) begin
        p <= a * b;
    end
endmodule

/* sv/polyblep_supersaw_voice_bank_unit.sv */
// supersaw voice bank top level: config registers, sequencer and datapath
// depends on psvb_pkg, psvb_ram, psvb_div, psvb_mul
// render: the divider runs three times (spread step, then one reciprocal per channel), the voice loop once per voice
// reset op: reads and rewrites every voice slot, no transaction on the result side
// throughput: one item at a time, set by the single multiplier and the serial divider
// after aresetn the voice memory is seeded in a sweep over all VOICES slots, s_ready low meanwhile
module polyblep_supersaw_voice_bank_unit
    import psvb_pkg::*;
#(
    parameter int VOICES         = 32,
    parameter int INSTANCE_INDEX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CFG_DW-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic [31:0]              s_phase_offset,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [23:0]       m_left_sample,
    output logic signed [23:0]       m_right_sample
);
    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int VW = $bits(voice_t);

    // seed of voice 0 and per-voice seed stride
    localparam logic [31:0] SEED_STEP = 32'd2654435761;
    localparam logic [31:0] SEED0 = 32'(64'd2166136261
        + 64'(INSTANCE_INDEX + 1) * 64'd16777619 + 64'd2654435761);

    localparam logic [32:0] ONE33 = 33'h1_0000_0000;
    localparam logic signed [35:0] ONE36 = 36'sd4294967296;

    // sequencer states
    localparam logic [4:0] ST_INIT    = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_SDIV_GO = 5'd2;
    localparam logic [4:0] ST_SDIV_WT = 5'd3;
    localparam logic [4:0] ST_V_READ  = 5'd4;
    localparam logic [4:0] ST_V_GEN   = 5'd5;
    localparam logic [4:0] ST_V_OFS   = 5'd6;
    localparam logic [4:0] ST_V_DRF   = 5'd7;
    localparam logic [4:0] ST_V_TPH   = 5'd8;
    localparam logic [4:0] ST_V_REG   = 5'd9;
    localparam logic [4:0] ST_V_HI    = 5'd10;
    localparam logic [4:0] ST_V_LO    = 5'd11;
    localparam logic [4:0] ST_V_SQ    = 5'd12;
    localparam logic [4:0] ST_V_SQM   = 5'd13;
    localparam logic [4:0] ST_V_ACC   = 5'd14;
    localparam logic [4:0] ST_C_GO    = 5'd15;
    localparam logic [4:0] ST_C_WT    = 5'd16;
    localparam logic [4:0] ST_C_MUL1  = 5'd17;
    localparam logic [4:0] ST_C_CLAMP = 5'd18;
    localparam logic [4:0] ST_C_MUL2  = 5'd19;
    localparam logic [4:0] ST_C_SAT   = 5'd20;
    localparam logic [4:0] ST_OUT     = 5'd21;
    localparam logic [4:0] ST_X_READ  = 5'd22;
    localparam logic [4:0] ST_X_WRITE = 5'd23;

    // configuration registers
    logic [31:0] pinc_reg;
    logic [47:0] inv_reg;
    logic [5:0]  vcnt_reg;
    logic [15:0] sgain_reg, rgain_reg, dgain_reg;
    logic [29:0] dstep_reg;
    logic [15:0] level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pinc_reg  <= '0;
            inv_reg   <= 48'd65536;
            vcnt_reg  <= 6'd1;
            sgain_reg <= '0;
            rgain_reg <= '0;
            dgain_reg <= '0;
            dstep_reg <= 30'd3920728;
            level_reg <= 16'd8192;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PHASE_INC:   pinc_reg  <= cfg_wdata[31:0];
                REG_INVERSE_INC: inv_reg   <= cfg_wdata[47:0];
                REG_VOICE_COUNT: vcnt_reg  <= cfg_wdata[5:0];
                REG_SPREAD_GAIN: sgain_reg <= cfg_wdata[15:0];
                REG_RANDOM_GAIN: rgain_reg <= cfg_wdata[15:0];
                REG_DRIFT_GAIN:  dgain_reg <= cfg_wdata[15:0];
                REG_DRIFT_STEP:  dstep_reg <= cfg_wdata[29:0];
                REG_OUT_LEVEL:   level_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] sg_sat, rg_sat, dg_sat;
    assign sg_sat = gain_sat(sgain_reg);
    assign rg_sat = gain_sat(rgain_reg);
    assign dg_sat = gain_sat(dgain_reg);

    // active voice count, clamped to 1..VOICES
    logic [CW-1:0] count_c;
    always_comb begin
        if (vcnt_reg == 6'd0) begin
            count_c = CW'(1);
        end else if (7'(vcnt_reg) > 7'(VOICES)) begin
            count_c = CW'(VOICES);
        end else begin
            count_c = CW'(vcnt_reg);
        end
    end

    // sequencer and work registers
    logic [4:0]         state_reg, state_next;
    logic [CW-1:0]      vidx_reg;
    logic [31:0]        seed_reg;
    logic [31:0]        offs_reg;
    logic [CW-1:0]      count_reg;
    logic [32:0]        q0_reg;
    logic [CW-1:0]      r0_reg;
    logic [31:0]        spq_reg;
    logic [CW-1:0]      spr_reg;
    voice_t             cur_reg;
    logic signed [32:0] d_reg;
    logic [31:0]        t_reg;
    logic [31:0]        u_reg;
    logic               rga_reg, rgb_reg;
    logic [32:0]        a_reg;
    logic               asat_reg;
    logic [32:0]        x_reg;
    logic signed [33:0] lsum_reg, rsum_reg;
    logic [CW-1:0]      lcnt_reg, rcnt_reg;
    logic               ch_reg;
    logic [24:0]        recip_reg;
    logic signed [20:0] v_reg;
    logic signed [23:0] lres_reg, rres_reg;
    logic               m_valid_reg;
    logic signed [23:0] m_left_reg, m_right_reg;

    // shared units
    logic               div_start, div_done;
    logic [32:0]        div_num, div_quo;
    logic [CW-1:0]      div_den, div_rem;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;

    psvb_div #(.NUM_W(33), .DEN_W(CW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    psvb_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // voice memory
    logic          ram_we;
    logic [VW-1:0] ram_wdata, ram_rdata;
    voice_t        ram_rd, wr_voice;

    assign ram_rd    = voice_t'(ram_rdata);
    assign ram_wdata = VW'(wr_voice);

    psvb_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (vidx_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (vidx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    logic [31:0] gen_rd, gen_seed;
    assign gen_rd   = xorshift32(ram_rd.gen);
    assign gen_seed = xorshift32(seed_reg);

    logic last_voice, last_slot;
    assign last_voice = CW'(vidx_reg + 1'b1) == count_reg;
    assign last_slot  = vidx_reg == CW'(VOICES - 1);

    // divider operands: spread step gain/count, then channel reciprocals
    logic [CW-1:0] chan_n;
    assign chan_n    = ch_reg ? rcnt_reg : lcnt_reg;
    assign div_start = (state_reg == ST_SDIV_GO) || (state_reg == ST_C_GO);
    assign div_num   = (state_reg == ST_SDIV_GO) ? {sg_sat, 17'd0}
                                                 : 33'd16777216 + 33'(chan_n >> 1);
    assign div_den   = (state_reg == ST_SDIV_GO) ? count_reg : chan_n;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_V_GEN: begin
                mul_a = {10'd0, gen_rd[31:8]};
                mul_b = {4'd0, dstep_reg};
            end
            ST_V_OFS: begin
                mul_a = {{10{cur_reg.offset[23]}}, cur_reg.offset};
                mul_b = {18'd0, rg_sat};
            end
            ST_V_DRF: begin
                mul_a = {d_reg[32], d_reg};
                mul_b = {18'd0, dg_sat};
            end
            ST_V_HI: begin
                mul_a = {2'd0, u_reg};
                mul_b = {2'd0, inv_reg[47:16]};
            end
            ST_V_LO: begin
                mul_a = {2'd0, u_reg};
                mul_b = {18'd0, inv_reg[15:0]};
            end
            ST_V_SQM: begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            ST_C_MUL1: begin
                mul_a = ch_reg ? rsum_reg : lsum_reg;
                mul_b = {9'd0, recip_reg};
            end
            ST_C_MUL2: begin
                mul_a = {{13{v_reg[20]}}, v_reg};
                mul_b = {18'd0, level_reg};
            end
            default: ;
        endcase
    end

    // reflecting random walk update
    logic signed [34:0] dsum, dref1, dref;
    always_comb begin
        dsum  = {{2{cur_reg.walk[32]}}, cur_reg.walk}
              + $signed({4'd0, prod[53:23]}) - $signed({5'd0, dstep_reg});
        dref1 = (dsum > 35'sd2147483648) ? 35'sd4294967296 - dsum : dsum;
        dref  = (dref1 < -35'sd2147483648) ? -35'sd4294967296 - dref1 : dref1;
    end

    // blep region and distance to the edge
    logic [32:0] dt;
    logic        rga_c, rgb_c;
    assign dt    = (pinc_reg == 32'd0) ? ONE33 : {1'b0, pinc_reg};
    assign rga_c = {1'b0, t_reg} < dt;
    assign rgb_c = !rga_c && ({1'b0, t_reg} > (ONE33 - dt));

    // ratio with saturation at 1.0
    logic        asat_c;
    logic [33:0] rsum_c;
    assign asat_c = (|prod[63:33]) || (prod[32] && (|prod[31:0]));
    assign rsum_c = {1'b0, a_reg} + {2'd0, prod[47:16]};

    // saw value with blep correction, floored to Q.19
    logic signed [35:0] xs36, sq36, blep, saw;
    logic signed [33:0] s34;
    always_comb begin
        xs36 = $signed({3'd0, x_reg});
        sq36 = $signed({3'd0, prod[64:32]});
        if (rga_reg) begin
            blep = (xs36 <<< 1) - sq36 - ONE36;
        end else if (rgb_reg) begin
            blep = sq36 - (xs36 <<< 1) + ONE36;
        end else begin
            blep = '0;
        end
        saw = $signed({3'd0, t_reg, 1'b0}) - ONE36 - blep;
        s34 = {{11{saw[35]}}, saw[35:13]};
    end

    // center voices feed both sides, the rest alternate by index parity
    logic to_both;
    assign to_both = (vidx_reg == '0) || ((vidx_reg == CW'(1)) && !count_reg[0]);

    // spread term steps by the quotient, remainder carried with one compare
    logic [CW:0] spr_sum;
    logic        spr_wrap;
    assign spr_sum  = {1'b0, spr_reg} + {1'b0, r0_reg};
    assign spr_wrap = spr_sum >= {1'b0, count_reg};

    // channel clamp and output saturation
    logic signed [43:0] vfull;
    logic signed [54:0] vout;
    logic signed [20:0] vclamp;
    logic signed [23:0] vsat;
    assign vfull = prod[67:24];
    assign vout  = prod[67:13];
    always_comb begin
        if (vfull > 44'sd786432) begin
            vclamp = 21'sd786432;
        end else if (vfull < -44'sd786432) begin
            vclamp = -21'sd786432;
        end else begin
            vclamp = vfull[20:0];
        end
        if (vout > 55'sd8388607) begin
            vsat = 24'sd8388607;
        end else if (vout < -55'sd8388608) begin
            vsat = -24'sd8388608;
        end else begin
            vsat = vout[23:0];
        end
    end

    // memory write select
    always_comb begin
        ram_we   = 1'b0;
        wr_voice = '0;
        case (state_reg)
            ST_INIT: begin
                ram_we          = 1'b1;
                wr_voice.gen    = gen_seed;
                wr_voice.offset = draw_of(gen_seed);
            end
            ST_X_WRITE: begin
                ram_we          = 1'b1;
                wr_voice.gen    = gen_rd;
                wr_voice.offset = draw_of(gen_rd);
            end
            ST_V_ACC: begin
                ram_we          = 1'b1;
                wr_voice.phase  = cur_reg.phase + pinc_reg;
                wr_voice.offset = cur_reg.offset;
                wr_voice.walk   = d_reg;
                wr_voice.gen    = cur_reg.gen;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:    if (last_slot) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_RESET) ? ST_X_READ : ST_SDIV_GO;
                end
            end
            ST_SDIV_GO: state_next = ST_SDIV_WT;
            ST_SDIV_WT: if (div_done) state_next = ST_V_READ;
            ST_V_READ:  state_next = ST_V_GEN;
            ST_V_GEN:   state_next = ST_V_OFS;
            ST_V_OFS:   state_next = ST_V_DRF;
            ST_V_DRF:   state_next = ST_V_TPH;
            ST_V_TPH:   state_next = ST_V_REG;
            ST_V_REG:   state_next = ST_V_HI;
            ST_V_HI:    state_next = ST_V_LO;
            ST_V_LO:    state_next = ST_V_SQ;
            ST_V_SQ:    state_next = ST_V_SQM;
            ST_V_SQM:   state_next = ST_V_ACC;
            ST_V_ACC:   state_next = last_voice ? ST_C_GO : ST_V_READ;
            ST_C_GO:    state_next = ST_C_WT;
            ST_C_WT:    if (div_done) state_next = ST_C_MUL1;
            ST_C_MUL1:  state_next = ST_C_CLAMP;
            ST_C_CLAMP: state_next = ST_C_MUL2;
            ST_C_MUL2:  state_next = ST_C_SAT;
            ST_C_SAT:   state_next = ch_reg ? ST_OUT : ST_C_GO;
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            ST_X_READ:  state_next = ST_X_WRITE;
            ST_X_WRITE: state_next = last_slot ? ST_IDLE : ST_X_READ;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            vidx_reg    <= '0;
            seed_reg    <= SEED0;
            m_valid_reg <= 1'b0;
            ch_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    seed_reg <= seed_reg + SEED_STEP;
                    vidx_reg <= last_slot ? '0 : CW'(vidx_reg + 1'b1);
                end
                ST_IDLE: begin
                    vidx_reg  <= '0;
                    offs_reg  <= s_phase_offset;
                    count_reg <= count_c;
                    spq_reg   <= '0;
                    spr_reg   <= '0;
                    lsum_reg  <= '0;
                    rsum_reg  <= '0;
                    lcnt_reg  <= '0;
                    rcnt_reg  <= '0;
                    ch_reg    <= 1'b0;
                end
                ST_SDIV_WT: begin
                    q0_reg <= div_quo;
                    r0_reg <= div_rem;
                end
                ST_V_GEN:   cur_reg <= {ram_rd.phase, ram_rd.offset, ram_rd.walk, gen_rd};
                ST_V_OFS:   d_reg <= dref[32:0];
                ST_V_DRF:   t_reg <= cur_reg.phase + offs_reg + spq_reg + prod[38:7];
                ST_V_TPH:   t_reg <= t_reg + prod[46:15];
                ST_V_REG: begin
                    rga_reg <= rga_c;
                    rgb_reg <= rgb_c;
                    u_reg   <= rga_c ? t_reg : 32'd0 - t_reg;
                end
                ST_V_LO: begin
                    a_reg    <= prod[32:0];
                    asat_reg <= asat_c;
                end
                ST_V_SQ: begin
                    x_reg <= (asat_reg || rsum_c > {1'b0, ONE33}) ? ONE33 : rsum_c[32:0];
                end
                ST_V_ACC: begin
                    if (to_both || !vidx_reg[0]) begin
                        lsum_reg <= lsum_reg + s34;
                        lcnt_reg <= CW'(lcnt_reg + 1'b1);
                    end
                    if (to_both || vidx_reg[0]) begin
                        rsum_reg <= rsum_reg + s34;
                        rcnt_reg <= CW'(rcnt_reg + 1'b1);
                    end
                    if (spr_wrap) begin
                        spr_reg <= CW'(spr_sum - {1'b0, count_reg});
                        spq_reg <= spq_reg + q0_reg[31:0] + 32'd1;
                    end else begin
                        spr_reg <= spr_sum[CW-1:0];
                        spq_reg <= spq_reg + q0_reg[31:0];
                    end
                    vidx_reg <= CW'(vidx_reg + 1'b1);
                end
                ST_C_WT:    recip_reg <= div_quo[24:0];
                ST_C_CLAMP: v_reg <= vclamp;
                ST_C_SAT: begin
                    if (ch_reg) begin
                        rres_reg <= vsat;
                    end else begin
                        lres_reg <= vsat;
                    end
                    ch_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_left_reg  <= lres_reg;
                        m_right_reg <= rres_reg;
                    end
                end
                ST_X_WRITE: vidx_reg <= last_slot ? '0 : CW'(vidx_reg + 1'b1);
                default: ;
            endcase
        end
    end

    assign s_ready        = state_reg == ST_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_left_sample  = m_left_reg;
    assign m_right_sample = m_right_reg;

    // walk written back stays within the reflecting bounds
    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_V_ACC) |-> (d_reg <= 33'sd2147483648 && d_reg >= -33'sd2147483648))
        else $error("drift walk out of range");

    // blep ratio saturates at one
    a_ratio_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_V_SQM) |-> (x_reg <= ONE33))
        else $error("blep ratio above one");

    // voice loop only visits active voices
    a_voice_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_V_READ) |-> (vidx_reg < count_reg))
        else $error("voice index past active count");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_SDIV_WT || state_reg == ST_C_WT))
        else $error("divider result not awaited");
endmodule

/* bench/polyblep_supersaw_voice_bank_unit_tb.sv */
// testbench for the supersaw voice bank: directed table, corner settings, then random renders and voice resets
// predicts every stereo sample with its own voice model; depends on psvb_pkg and the rtl
`timescale 1ns / 1ps

module polyblep_supersaw_voice_bank_unit_tb;
    import psvb_pkg::*;

    localparam int NV = 32;
    localparam longint ONE = 64'sd4294967296;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = OP_RENDER;
    logic [31:0] s_phase_offset = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_left_sample, m_right_sample;

    always #5 aclk = ~aclk;

    polyblep_supersaw_voice_bank_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_phase_offset(s_phase_offset),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_sample(m_left_sample), .m_right_sample(m_right_sample)
    );

    // shadow copy of the registers
    logic [31:0] step_q;
    logic [47:0] inv_q;
    logic [5:0]  count_q;
    logic [15:0] spread_q, rand_q, dgain_q, level_q;
    logic [29:0] dstep_q;

    // shadow copy of the voice memory
    logic [31:0]        ph_m  [NV];
    logic signed [23:0] off_m [NV];
    longint             walk_m[NV];
    logic [31:0]        gen_m [NV];

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } stereo_t;

    stereo_t sample_q[$];
    int  mismatches = 0;
    bit  stall_free = 0;
    longint cycles = 0;

    function automatic longint fl(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] gen_step(input logic [31:0] g);
        logic [31:0] x;
        x = g ^ (g << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    function automatic longint ratio(longint t);
        longint hi, lo, a, r;
        hi = longint'(inv_q >> 16);
        lo = longint'(inv_q & 48'hFFFF);
        a = t * hi;
        if (hi != 0 && t > ONE / hi + 1) return ONE;
        if (a > ONE) return ONE;
        r = a + ((t * lo) >> 16);
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic longint sq(longint x);
        if (x >= ONE) return ONE;
        return longint'((64'(x) * 64'(x)) >> 32);
    endfunction

    function automatic longint saw(logic [31:0] t);
        longint dt, tt, blep, x;
        dt = (step_q != 0) ? longint'(step_q) : ONE;
        tt = longint'(t);
        blep = 0;
        if (tt < dt) begin
            x = ratio(tt);
            blep = 2 * x - sq(x) - ONE;
        end else if (tt > ONE - dt) begin
            x = ratio(ONE - tt);
            blep = sq(x) - 2 * x + ONE;
        end
        return 2 * tt - ONE - blep;
    endfunction

    function automatic logic signed [23:0] chan(longint total, int n);
        longint recip, v;
        recip = ((64'sd1 << 24) + n / 2) / n;
        v = fl(total * recip, 24);
        if (v > 786432) v = 786432;
        if (v < -786432) v = -786432;
        v = fl(v * longint'(level_q), 13);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return 24'(v);
    endfunction

    task automatic reseed();
        for (int v = 0; v < NV; v++) begin
            gen_m[v] = 32'd2166136261 + 32'd16777619 + 32'(v + 1) * 32'd2654435761;
            gen_m[v] = gen_step(gen_m[v]);
            off_m[v] = draw_of(gen_m[v]);
            ph_m[v] = '0;
            walk_m[v] = 0;
        end
    endtask

    task automatic cfg_shadow(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        case (idx)
            REG_PHASE_INC:   step_q   = val[31:0];
            REG_INVERSE_INC: inv_q    = val[47:0];
            REG_VOICE_COUNT: count_q  = val[5:0];
            REG_SPREAD_GAIN: spread_q = val[15:0];
            REG_RANDOM_GAIN: rand_q   = val[15:0];
            REG_DRIFT_GAIN:  dgain_q  = val[15:0];
            REG_DRIFT_STEP:  dstep_q  = val[29:0];
            REG_OUT_LEVEL:   level_q  = val[15:0];
            default: ;
        endcase
    endtask

    // advance the voice bank by one transaction, return the stereo sample for a render
    function automatic bit bank_tick(logic op, logic [31:0] offs, output stereo_t res);
        int n, lc, rc;
        longint ls, rs, d, s, sg, rg, dg;
        logic [31:0] w, t;
        res = '0;
        if (op == OP_RESET) begin
            for (int i = 0; i < NV; i++) begin
                ph_m[i] = '0;
                walk_m[i] = 0;
                gen_m[i] = gen_step(gen_m[i]);
                off_m[i] = draw_of(gen_m[i]);
            end
            return 0;
        end
        n = (count_q == 0) ? 1 : ((count_q > NV) ? NV : int'(count_q));
        sg = longint'(gain_sat(spread_q));
        rg = longint'(gain_sat(rand_q));
        dg = longint'(gain_sat(dgain_q));
        ls = 0; rs = 0; lc = 0; rc = 0;
        for (int i = 0; i < n; i++) begin
            gen_m[i] = gen_step(gen_m[i]);
            w = gen_m[i];
            d = walk_m[i] + (((longint'(w >> 8) * longint'(dstep_q)) >>> 23)
                - longint'(dstep_q));
            if (d > 64'sd2147483648) d = ONE - d;
            if (d < -64'sd2147483648) d = -ONE - d;
            walk_m[i] = d;
            t = ph_m[i] + offs;
            t += 32'(((longint'(i) * sg) <<< 17) / n);
            t += 32'(fl(longint'(off_m[i]) * rg, 7));
            t += 32'(fl(d * dg, 15));
            s = fl(saw(t), 13);
            ph_m[i] = ph_m[i] + step_q;
            if (i == 0 || (i == 1 && n % 2 == 0)) begin
                ls += s; rs += s; lc++; rc++;
            end else if (i % 2 == 0) begin
                ls += s; lc++;
            end else begin
                rs += s; rc++;
            end
        end
        res.left = chan(ls, lc);
        res.right = chan(rs, rc);
        return 1;
    endfunction

    // drive one register write, at a falling edge
    task automatic reg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_shadow(idx, val);
    endtask

    // send one transaction, predicting it at acceptance time
    task automatic send_item(logic op, logic [31:0] offs, bit pin, stereo_t pinned);
        stereo_t r;
        while (!stall_free && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_phase_offset <= offs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (bank_tick(op, offs, r)) sample_q.push_back(pin ? pinned : r);
        @(negedge aclk);
    endtask

    // idle point: drain the queue, then let a reset op finish inside the block
    task automatic drain();
        s_valid <= 1'b0;
        while (sample_q.size() != 0) @(negedge aclk);
        repeat (2 * NV + 20) @(negedge aclk);
    endtask

    task automatic program_regs(logic [31:0] inc, logic [5:0] n, logic [15:0] sp,
                                logic [15:0] rg, logic [15:0] dg, logic [29:0] ds,
                                logic [15:0] lv);
        logic [47:0] inv;
        inv = (inc == 0) ? 48'd65536 : 48'((64'd1 << 48) / inc);
        if (inv == 0) inv = 48'd65536;
        reg_write(REG_PHASE_INC, inc);
        reg_write(REG_INVERSE_INC, inv);
        reg_write(REG_VOICE_COUNT, n);
        reg_write(REG_SPREAD_GAIN, sp);
        reg_write(REG_RANDOM_GAIN, rg);
        reg_write(REG_DRIFT_GAIN, dg);
        reg_write(REG_DRIFT_STEP, ds);
        reg_write(REG_OUT_LEVEL, lv);
    endtask

    // result side: random backpressure, compare with the oldest prediction
    always @(negedge aclk) begin
        if (aresetn) m_ready <= stall_free || ($urandom_range(99) >= 14);
    end

    always @(posedge aclk) begin
        stereo_t exp_s;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sample %0d %0d",
                                               m_left_sample, m_right_sample);
            end else begin
                exp_s = sample_q.pop_front();
                if (exp_s.left !== m_left_sample || exp_s.right !== m_right_sample) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: exp %0d/%0d got %0d/%0d", exp_s.left,
                                 exp_s.right, m_left_sample, m_right_sample);
                end
            end
        end
        if (cycles > 64'd3000000) begin
            $display("polyblep_supersaw_voice_bank_unit_tb failed");
            $finish;
        end
    end

    // directed stimulus table: op, offset, whether the sample is typed in
    typedef struct {
        logic        op;
        logic [31:0] offs;
        bit          pin;
        stereo_t     want;
    } row_t;

    row_t rows[$];

    initial begin
        stereo_t none;
        int limit;
        none = '0;
        step_q = 0; inv_q = 48'd65536; count_q = 1; spread_q = 0; rand_q = 0;
        dgain_q = 0; dstep_q = 30'd3920728; level_q = 16'd8192;
        reseed();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // after reset one voice at phase zero sits at the start of the blep region
        // with zero step: the edge correction cancels the saw, so both sides are zero
        rows.push_back('{OP_RENDER, 32'h0, 1'b1, none});
        rows.push_back('{OP_RENDER, 32'hFFFF_FFFF, 1'b0, none});
        rows.push_back('{OP_RENDER, 32'h8000_0000, 1'b0, none});
        rows.push_back('{OP_RESET, 32'h1234_5678, 1'b0, none});
        rows.push_back('{OP_RENDER, 32'h5555_5555, 1'b0, none});
        rows.push_back('{OP_RENDER, 32'hAAAA_AAAA, 1'b0, none});
        foreach (rows[k]) send_item(rows[k].op, rows[k].offs, rows[k].pin, rows[k].want);
        drain();

        // extreme setting: all voices, full gains, the largest walk step of the random phases, max level
        program_regs(32'h0100_0000, 6'd32, GAIN_ONE, GAIN_ONE, GAIN_ONE, 30'd858993459,
                     16'hFFFF);
        for (int k = 0; k < 8; k++) send_item(OP_RENDER, $urandom, 0, none);
        send_item(OP_RESET, 32'h0, 0, none);
        drain();
        // gains past 1.0, count 0 and above 32, zero level gives silence
        program_regs(32'hFFFF_FFFF, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 30'h3FFF_FFFF,
                     16'd0);
        send_item(OP_RENDER, 32'h0, 1, none);
        drain();
        program_regs(32'd0, 6'd0, 16'd0, 16'd0, 16'd0, 30'd0, 16'd8192);
        send_item(OP_RENDER, 32'h0, 0, none);
        drain();
        // inconsistent reciprocal saturates the blep terms
        reg_write(REG_INVERSE_INC, 48'hFFFF_FFFF_FFFF);
        reg_write(REG_PHASE_INC, 32'h4000_0000);
        for (int k = 0; k < 4; k++) send_item(OP_RENDER, $urandom, 0, none);
        drain();

        // random phases, each with its own setting
        for (int ph = 0; ph < 12; ph++) begin
            program_regs($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                         ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(32, 1)),
                         16'($urandom_range(32768)), 16'($urandom_range(32768)),
                         16'($urandom_range(32768)), 30'($urandom_range(858993459)),
                         16'($urandom));
            stall_free = (ph == 5);
            limit = $urandom_range(70, 110);
            for (int k = 0; k < limit; k++)
                send_item(($urandom_range(19) == 0) ? OP_RESET : OP_RENDER, $urandom, 0, none);
            drain();
        end
        stall_free = 0;

        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("polyblep_supersaw_voice_bank_unit_tb passed");
        end else begin
            $display("polyblep_supersaw_voice_bank_unit_tb failed");
        end
        $finish;
    end

endmodule
